@@ rtl/g3m_pkg.sv @@
`default_nettype none

package g3m_pkg;

  localparam int MaxWidth   = 2048;
  localparam int MaxHeight  = 4096;
  localparam int MinSize    = 5;
  localparam int AddrW      = $clog2(MaxWidth);

  localparam int PixW       = 8;
  localparam int ColW       = 11;
  localparam int RowW       = 12;
  localparam int WidthW     = 12;
  localparam int HeightW    = 13;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int InDataW    = 3 * PixW;
  localparam int OutFieldW  = 4 * PixW + RowW + ColW;
  localparam int OutDataW   = ((OutFieldW + 7) / 8) * 8;
  localparam int NumCols    = 3;

  localparam int ResetWidth  = 640;
  localparam int ResetHeight = 480;

  // Interior border: gray is kept from this row/column on, and a result is produced
  // once the raster position is one further in.
  localparam int Border     = 2;
  localparam int ProdFirst  = 3;

  localparam int GrayW      = 18;
  localparam int CoefRed    = 306;
  localparam int CoefGreen  = 601;
  localparam int CoefBlue   = 116;
  localparam int GrayRound  = 512;
  localparam int GrayShift  = 10;

  localparam int Sum8W      = 11;
  localparam int GaussW     = 12;
  localparam int MeanRound  = 4;
  localparam int MeanShift  = 3;
  localparam int GaussRound = 8;
  localparam int GaussShift = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1
  } cfg_idx_e;

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  typedef struct packed {
    logic            produce;
    logic            frame_end;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } tag_t;

  typedef struct packed {
    logic              frame_end;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    pix_t              center;
    logic [Sum8W-1:0]  sum8;
    logic [GaussW-1:0] gsum;
    pix_t              lo_max;
    pix_t              mid_med;
    pix_t              hi_min;
  } partial_t;

  typedef struct packed {
    logic            frame_end;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    pix_t            gauss;
    pix_t            median;
    pix_t            mean;
    pix_t            center;
  } result_t;

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Three compare-exchange steps; the result has the smallest value in top.
  function automatic column_t sort3(column_t c);
    pix_t a;
    pix_t b;
    pix_t d;
    pix_t t;
    a = c.top;
    b = c.mid;
    d = c.bot;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    if (b > d) begin
      t = b;
      b = d;
      d = t;
    end
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    return '{top: a, mid: b, bot: d};
  endfunction

endpackage

`default_nettype wire

@@ rtl/g3m_line_ram.sv @@
`default_nettype none

module g3m_line_ram (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [g3m_pkg::AddrW-1:0] rd_addr_i,
  output g3m_pkg::line_pair_t    rd_data_o,
  input  logic                   wr_en_i,
  input  logic [g3m_pkg::AddrW-1:0] wr_addr_i,
  input  g3m_pkg::line_pair_t    wr_data_i
);

  g3m_pkg::line_pair_t mem [g3m_pkg::MaxWidth];
  g3m_pkg::line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/g3m_col_cell.sv @@
`default_nettype none

// One window column. It keeps the raw pixels and a sorted copy for the
// median, and passes the raw pixels to its neighbor on the next shift.
module g3m_col_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  g3m_pkg::column_t  col_i,
  output g3m_pkg::column_t  col_o,
  output g3m_pkg::column_t  sorted_o
);

  g3m_pkg::column_t col_q;
  g3m_pkg::column_t sorted_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q    <= col_i;
      sorted_q <= g3m_pkg::sort3(col_i);
    end
  end

  assign col_o    = col_q;
  assign sorted_o = sorted_q;

endmodule

`default_nettype wire

@@ rtl/g3m_reduce.sv @@
`default_nettype none

// Reduces the 3x3 window to sums and the three median candidates.
// Column 0 is the newest (right), column 2 the oldest (left).
module g3m_reduce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  g3m_pkg::tag_t     tag_i,
  input  g3m_pkg::column_t  win_i    [g3m_pkg::NumCols],
  input  g3m_pkg::column_t  sorted_i [g3m_pkg::NumCols],
  output logic              valid_o,
  output g3m_pkg::partial_t part_o
);

  logic              valid_q;
  g3m_pkg::partial_t part_q;
  g3m_pkg::partial_t part_d;

  always_comb begin
    part_d.frame_end = tag_i.frame_end;
    part_d.row       = tag_i.row;
    part_d.col       = tag_i.col;
    part_d.center    = win_i[1].mid;
    part_d.sum8 = g3m_pkg::Sum8W'(win_i[0].top) + g3m_pkg::Sum8W'(win_i[0].mid)
                + g3m_pkg::Sum8W'(win_i[0].bot) + g3m_pkg::Sum8W'(win_i[1].top)
                + g3m_pkg::Sum8W'(win_i[1].bot) + g3m_pkg::Sum8W'(win_i[2].top)
                + g3m_pkg::Sum8W'(win_i[2].mid) + g3m_pkg::Sum8W'(win_i[2].bot);
    part_d.gsum = g3m_pkg::GaussW'(win_i[0].top) + g3m_pkg::GaussW'(win_i[0].bot)
                + g3m_pkg::GaussW'(win_i[2].top) + g3m_pkg::GaussW'(win_i[2].bot)
                + (g3m_pkg::GaussW'(win_i[0].mid) << 1)
                + (g3m_pkg::GaussW'(win_i[2].mid) << 1)
                + (g3m_pkg::GaussW'(win_i[1].top) << 1)
                + (g3m_pkg::GaussW'(win_i[1].bot) << 1)
                + (g3m_pkg::GaussW'(win_i[1].mid) << 2);
    // Median of nine from sorted columns: the largest low, the middle
    // middle and the smallest high; their median is the window median.
    part_d.lo_max  = g3m_pkg::max3(sorted_i[0].top, sorted_i[1].top, sorted_i[2].top);
    part_d.mid_med = g3m_pkg::med3(sorted_i[0].mid, sorted_i[1].mid, sorted_i[2].mid);
    part_d.hi_min  = g3m_pkg::min3(sorted_i[0].bot, sorted_i[1].bot, sorted_i[2].bot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_q <= part_d;
    end
  end

  assign valid_o = valid_q;
  assign part_o  = part_q;

endmodule

`default_nettype wire

@@ rtl/gray_3x3_mean_median_gauss.sv @@
// Stages: input and line store read, gray and column assembly, column cells,
// reduction, output register. Throughput: one pixel per cycle while the
// skid register is empty, as the line store reads and writes once per cycle.
// Reset: frame size 640x480, raster position 0,0, pipeline and output empty.
// Line store contents stay undefined after reset; there is no clearing pass.
`default_nettype none

module gray_3x3_mean_median_gauss (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [g3m_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [g3m_pkg::CfgDataW-1:0]   cfg_data_i,
  // Pixel input.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: red, green, blue (from bit 0 up).
  input  logic [g3m_pkg::InDataW-1:0]    s_axis_tdata,
  // Result output.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: center_gray, mean_value, median_value, gauss_value, out_row,
  // out_col, one zero pad bit (from bit 0 up).
  output logic [g3m_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int ColW    = g3m_pkg::ColW;
  localparam int RowW    = g3m_pkg::RowW;
  localparam int WidthW  = g3m_pkg::WidthW;
  localparam int HeightW = g3m_pkg::HeightW;
  localparam int GrayW   = g3m_pkg::GrayW;
  localparam int PixW    = g3m_pkg::PixW;
  localparam int NumCols = g3m_pkg::NumCols;

  // ---------------- configuration ----------------
  logic               cfg_we;
  logic               cfg_restart;
  logic [WidthW-1:0]  w_sat;
  logic [HeightW-1:0] h_sat;
  logic [ColW-1:0]    w_last_q, w_int_q, w_prod_q;
  logic [RowW-1:0]    h_last_q, h_int_q, h_prod_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_restart = cfg_we && ((cfg_index_i == g3m_pkg::CfgFrameWidth) ||
                                  (cfg_index_i == g3m_pkg::CfgFrameHeight));

  always_comb begin
    w_sat = cfg_data_i[WidthW-1:0];
    if (w_sat < WidthW'(g3m_pkg::MinSize)) begin
      w_sat = WidthW'(g3m_pkg::MinSize);
    end else if (w_sat > WidthW'(g3m_pkg::MaxWidth)) begin
      w_sat = WidthW'(g3m_pkg::MaxWidth);
    end
    h_sat = cfg_data_i[HeightW-1:0];
    if (h_sat < HeightW'(g3m_pkg::MinSize)) begin
      h_sat = HeightW'(g3m_pkg::MinSize);
    end else if (h_sat > HeightW'(g3m_pkg::MaxHeight)) begin
      h_sat = HeightW'(g3m_pkg::MaxHeight);
    end
  end

  // Only the derived limits are kept: last index, last interior index and
  // last index at which a result is produced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= ColW'(g3m_pkg::ResetWidth - 1);
      w_int_q  <= ColW'(g3m_pkg::ResetWidth - 1 - g3m_pkg::Border);
      w_prod_q <= ColW'(g3m_pkg::ResetWidth - g3m_pkg::Border);
      h_last_q <= RowW'(g3m_pkg::ResetHeight - 1);
      h_int_q  <= RowW'(g3m_pkg::ResetHeight - 1 - g3m_pkg::Border);
      h_prod_q <= RowW'(g3m_pkg::ResetHeight - g3m_pkg::Border);
    end else if (cfg_we) begin
      if (cfg_index_i == g3m_pkg::CfgFrameWidth) begin
        w_last_q <= ColW'(w_sat - WidthW'(1));
        w_int_q  <= ColW'(w_sat - WidthW'(1 + g3m_pkg::Border));
        w_prod_q <= ColW'(w_sat - WidthW'(g3m_pkg::Border));
      end
      if (cfg_index_i == g3m_pkg::CfgFrameHeight) begin
        h_last_q <= RowW'(h_sat - HeightW'(1));
        h_int_q  <= RowW'(h_sat - HeightW'(1 + g3m_pkg::Border));
        h_prod_q <= RowW'(h_sat - HeightW'(g3m_pkg::Border));
      end
    end
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic s_accept;
  logic skid_valid_q;

  // Everything moves unless a result sits in the skid register.
  assign adv           = !skid_valid_q;
  assign s_axis_tready = adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // ---------------- raster position ----------------
  logic [RowW-1:0] r_q;
  logic [ColW-1:0] c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      c_q <= '0;
    end else if (cfg_restart) begin
      r_q <= '0;
      c_q <= '0;
    end else if (s_accept) begin
      if (c_q == w_last_q) begin
        c_q <= '0;
        r_q <= (r_q == h_last_q) ? '0 : r_q + RowW'(1);
      end else begin
        c_q <= c_q + ColW'(1);
      end
    end
  end

  logic          interior;
  g3m_pkg::tag_t tag_d;

  always_comb begin
    interior = (r_q >= RowW'(g3m_pkg::Border)) && (r_q <= h_int_q) &&
               (c_q >= ColW'(g3m_pkg::Border)) && (c_q <= w_int_q);
    tag_d.produce   = (r_q >= RowW'(g3m_pkg::ProdFirst)) && (r_q <= h_prod_q) &&
                      (c_q >= ColW'(g3m_pkg::ProdFirst)) && (c_q <= w_prod_q);
    tag_d.frame_end = (r_q == h_prod_q) && (c_q == w_prod_q);
    tag_d.row       = r_q - RowW'(1);
    tag_d.col       = c_q - ColW'(1);
  end

  // ---------------- stage 1: input and line store read ----------------
  logic                        p1_valid_q;
  g3m_pkg::tag_t               p1_tag_q;
  logic                        p1_interior_q;
  logic [g3m_pkg::InDataW-1:0] p1_rgb_q;
  logic [g3m_pkg::AddrW-1:0]   p1_addr_q;
  logic [g3m_pkg::AddrW-1:0]   rd_addr;
  g3m_pkg::line_pair_t         ram_rd;
  g3m_pkg::line_pair_t         ram_wr;
  logic                        ram_we;

  assign rd_addr = g3m_pkg::AddrW'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (adv) begin
      p1_valid_q <= s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      p1_tag_q      <= tag_d;
      p1_interior_q <= interior;
      p1_rgb_q      <= s_axis_tdata;
      p1_addr_q     <= rd_addr;
    end
  end

  g3m_line_ram u_line_ram (
    .clk_i     (clk_i),
    .rd_en_i   (s_accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rd),
    .wr_en_i   (ram_we),
    .wr_addr_i (p1_addr_q),
    .wr_data_i (ram_wr)
  );

  // ---------------- stage 2: gray and column assembly ----------------
  logic [GrayW-1:0] gray_sum;
  logic [PixW-1:0]  gray;
  g3m_pkg::column_t col_d;
  g3m_pkg::column_t col_p2_q;
  logic             p2_valid_q;
  g3m_pkg::tag_t    p2_tag_q;

  always_comb begin
    gray_sum = GrayW'(p1_rgb_q[0 +: PixW])      * GrayW'(g3m_pkg::CoefRed)
             + GrayW'(p1_rgb_q[PixW +: PixW])   * GrayW'(g3m_pkg::CoefGreen)
             + GrayW'(p1_rgb_q[2*PixW +: PixW]) * GrayW'(g3m_pkg::CoefBlue)
             + GrayW'(g3m_pkg::GrayRound);
    gray   = p1_interior_q ? gray_sum[g3m_pkg::GrayShift +: PixW] : '0;
    col_d  = '{top: ram_rd.upper, mid: ram_rd.middle, bot: gray};
    // The line one up moves to the upper store; this pixel takes its place.
    ram_wr = '{upper: ram_rd.middle, middle: gray};
  end

  assign ram_we = adv && p1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (adv) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      col_p2_q <= col_d;
      p2_tag_q <= p1_tag_q;
    end
  end

  // ---------------- stage 3: chain of window column cells ----------------
  logic             cell_shift;
  g3m_pkg::column_t cell_in    [NumCols];
  g3m_pkg::column_t win_raw    [NumCols];
  g3m_pkg::column_t win_sorted [NumCols];
  logic             p3_valid_q;
  g3m_pkg::tag_t    p3_tag_q;

  assign cell_shift = adv && p2_valid_q;
  assign cell_in[0] = col_p2_q;

  for (genvar i = 0; i < NumCols; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cell_in[i] = win_raw[i-1];
    end
    g3m_col_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (cell_shift),
      .col_i    (cell_in[i]),
      .col_o    (win_raw[i]),
      .sorted_o (win_sorted[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else if (adv) begin
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_shift) begin
      p3_tag_q <= p2_tag_q;
    end
  end

  // ---------------- stage 4: window reduction ----------------
  logic              red_valid;
  g3m_pkg::partial_t red_part;

  g3m_reduce u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (p3_valid_q && p3_tag_q.produce),
    .tag_i    (p3_tag_q),
    .win_i    (win_raw),
    .sorted_i (win_sorted),
    .valid_o  (red_valid),
    .part_o   (red_part)
  );

  // ---------------- output register and skid ----------------
  logic                     res_v;
  g3m_pkg::result_t         res_d;
  logic [g3m_pkg::Sum8W:0]  mean_sum;
  logic [g3m_pkg::GaussW:0] gauss_sum;
  g3m_pkg::result_t         out_q;
  g3m_pkg::result_t         skid_q;
  logic                     out_valid_q;
  logic                     out_free;

  always_comb begin
    mean_sum  = (g3m_pkg::Sum8W+1)'(red_part.sum8) + (g3m_pkg::Sum8W+1)'(g3m_pkg::MeanRound);
    gauss_sum = (g3m_pkg::GaussW+1)'(red_part.gsum)
              + (g3m_pkg::GaussW+1)'(g3m_pkg::GaussRound);
    res_d.frame_end = red_part.frame_end;
    res_d.col       = red_part.col;
    res_d.row       = red_part.row;
    res_d.center    = red_part.center;
    res_d.mean      = mean_sum[g3m_pkg::MeanShift +: PixW];
    res_d.gauss     = gauss_sum[g3m_pkg::GaussShift +: PixW];
    res_d.median    = g3m_pkg::med3(red_part.lo_max, red_part.mid_med, red_part.hi_min);
  end

  assign res_v    = adv && red_valid;
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_v;
      skid_valid_q <= 1'b0;
    end else if (res_v) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_v) begin
        out_q <= res_d;
      end
    end else if (res_v) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.frame_end;
  assign m_axis_tdata  = {(g3m_pkg::OutDataW - g3m_pkg::OutFieldW)'(0),
                          out_q.col, out_q.row, out_q.gauss, out_q.median,
                          out_q.mean, out_q.center};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output is empty");

  a_ram_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && ram_we) |-> (rd_addr != p1_addr_q))
    else $error("line store read and write hit the same entry");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !cfg_restart) |=>
      (c_q == (($past(c_q) == $past(w_last_q)) ? '0 : $past(c_q) + ColW'(1))))
    else $error("column counter did not step by one item");

  a_frame_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_end) |->
      ((out_q.col == w_prod_q - ColW'(1)) && (out_q.row == h_prod_q - RowW'(1))))
    else $error("frame end flagged away from the last interior center");
`endif

endmodule

`default_nettype wire

@@ bench/g3m_filter_checker.sv @@
module g3m_filter_checker
  import g3m_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [InDataW-1:0]  s_data_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutDataW-1:0] m_data_i,
  input  logic                m_last_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  frame_ends_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [8:0][PixW-1:0] window_t;

  localparam int MaxPrinted = 30;

  logic [WidthW-1:0]  width_reg;
  logic [HeightW-1:0] height_reg;
  pix_t               line_upper  [MaxWidth];
  pix_t               line_middle [MaxWidth];
  column_t            col_far;
  column_t            col_near;
  int unsigned        row_pos;
  int unsigned        col_pos;
  int                 error_count;
  int                 result_count;
  int                 frame_end_count;
  result_t            filter_results_q [$];

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < MinSize) return MinSize;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pix_t median_of_nine(window_t w);
    pix_t v [9];
    pix_t t;
    for (int i = 0; i < 9; i++) v[i] = w[i];
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8 - i; j++) begin
        if (v[j] > v[j + 1]) begin
          t = v[j];
          v[j] = v[j + 1];
          v[j + 1] = t;
        end
      end
    end
    return v[4];
  endfunction

  task automatic report(input string msg);
    if (error_count < MaxPrinted) $display("g3m checker: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got, input result_t at);
    if (want != got) begin
      report($sformatf("%s of result at row %0d col %0d: expected %0d, got %0d",
                       name, at.row, at.col, want, got));
    end
  endtask

  // Works out the window that this pixel completes and queues the result
  // for its center when the center lies in the interior.
  task automatic filter_pixel(input logic [InDataW-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned red;
    int unsigned green;
    int unsigned blue;
    int unsigned luma;
    int unsigned sum8;
    int unsigned wsum;
    window_t     win;
    result_t     res;
    w = clamp_size(width_reg, MaxWidth);
    h = clamp_size(height_reg, MaxHeight);
    r = row_pos;
    c = col_pos;
    red = px[7:0];
    green = px[15:8];
    blue = px[23:16];
    luma = (CoefRed * red + CoefGreen * green + CoefBlue * blue + GrayRound) >> GrayShift;
    if (!(r >= 2 && r + 3 <= h && c >= 2 && c + 3 <= w)) luma = 0;

    win[0] = col_far.top;
    win[1] = col_near.top;
    win[2] = line_upper[c];
    win[3] = col_far.mid;
    win[4] = col_near.mid;
    win[5] = line_middle[c];
    win[6] = col_far.bot;
    win[7] = col_near.bot;
    win[8] = luma[PixW-1:0];

    if (r >= 3 && r + 2 <= h && c >= 3 && c + 2 <= w) begin
      sum8 = win[0] + win[1] + win[2] + win[3] + win[5] + win[6] + win[7] + win[8];
      wsum = win[0] + 2 * win[1] + win[2] + 2 * win[3] + 4 * win[4] + 2 * win[5]
             + win[6] + 2 * win[7] + win[8];
      res.center = win[4];
      res.mean = pix_t'((4 + sum8) / 8);
      res.median = median_of_nine(win);
      res.gauss = pix_t'((8 + wsum) / 16);
      res.row = RowW'(r - 1);
      res.col = ColW'(c - 1);
      res.frame_end = (r + 2 == h) && (c + 2 == w);
      filter_results_q.push_back(res);
    end

    col_far = col_near;
    col_near = '{top: win[2], mid: win[5], bot: win[8]};
    line_upper[c] = win[5];
    line_middle[c] = win[8];

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      width_reg = WidthW'(ResetWidth);
      height_reg = HeightW'(ResetHeight);
      for (int i = 0; i < MaxWidth; i++) begin
        line_upper[i] = '0;
        line_middle[i] = '0;
      end
      col_far = '0;
      col_near = '0;
      row_pos = 0;
      col_pos = 0;
      filter_results_q.delete();
      error_count = 0;
      result_count = 0;
      frame_end_count = 0;
    end else begin
      // A write to either size register starts a new frame; other indexes do nothing.
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgFrameWidth) begin
          width_reg = cfg_data_i[WidthW-1:0];
          row_pos = 0;
          col_pos = 0;
        end else if (cfg_index_i == CfgFrameHeight) begin
          height_reg = cfg_data_i[HeightW-1:0];
          row_pos = 0;
          col_pos = 0;
        end
      end
      if (s_valid_i && s_ready_i) filter_pixel(s_data_i);
      if (m_valid_i && m_ready_i) begin
        got = result_t'({m_last_i, m_data_i[OutFieldW-1:0]});
        result_count++;
        if (got.frame_end) frame_end_count++;
        if (m_data_i[OutDataW-1:OutFieldW] != '0) begin
          report($sformatf("pad bits set in result at row %0d col %0d", got.row, got.col));
        end
        if (filter_results_q.size() == 0) begin
          report($sformatf("result at row %0d col %0d with nothing expected",
                           got.row, got.col));
        end else begin
          want = filter_results_q.pop_front();
          check_field("center_gray", want.center, got.center, want);
          check_field("mean_value", want.mean, got.mean, want);
          check_field("median_value", want.median, got.median, want);
          check_field("gauss_value", want.gauss, got.gauss, want);
          check_field("out_row", want.row, got.row, want);
          check_field("out_col", want.col, got.col, want);
          check_field("frame_end", want.frame_end, got.frame_end, want);
        end
      end
    end
    errors_o <= error_count;
    pending_o <= filter_results_q.size();
    results_o <= result_count;
    frame_ends_o <= frame_end_count;
  end

endmodule

@@ bench/tb.sv @@
module tb;
  import g3m_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 1_000_000;
  localparam int HoldCycles    = 400;
  localparam int RandomTarget  = 250;
  localparam int PressureItems = 150;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef enum {PixRandom, PixExtreme, PixFlat, PixCorner} pix_mode_e;
  typedef enum {RxOpen, RxHalf, RxSparse, RxEveryThird} rx_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int error_count;
  int pending_count;
  int result_count;
  int frame_end_count;

  int cycles = 0;
  int hold_req = 0;
  int gap_max = 0;
  int burst_left = 0;
  int pixels_sent = 0;
  int random_items = 0;
  int settings_used = 0;
  int unsigned cur_w = ResetWidth;
  int unsigned cur_h = ResetHeight;

  gray_3x3_mean_median_gauss dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  g3m_filter_checker filter_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .errors_o     (error_count),
    .pending_o    (pending_count),
    .results_o    (result_count),
    .frame_ends_o (frame_end_count)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: errors");
      $finish;
    end
  end

  // Output side: stalls follow a randomly chosen pattern that is redrawn once
  // its random run ends, and a hold request closes the output for a long stretch.
  initial begin
    int       hold_seen;
    int       hold_left;
    int       mode_left;
    int       tick;
    rx_mode_e mode;
    logic     ready;
    hold_seen = 0;
    hold_left = 0;
    mode_left = 0;
    tick = 0;
    mode = RxOpen;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          RxOpen:   ready = 1'b1;
          RxHalf:   ready = 1'($urandom_range(0, 1));
          RxSparse: ready = ($urandom_range(0, 3) == 0);
          default:  ready = (tick % 3 != 0);
        endcase
      end
      m_axis_tready <= ready;
    end
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < MinSize) return MinSize;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [InDataW-1:0] make_pixel(pix_mode_e mode, int n);
    pix_t r;
    pix_t g;
    pix_t b;
    pix_t level;
    r = pix_t'($urandom);
    g = pix_t'($urandom);
    b = pix_t'($urandom);
    case (mode)
      PixCorner: begin
        case (n % 6)
          0: {r, g, b} = '0;
          1: {r, g, b} = '1;
          2: {r, g, b} = {8'hff, 8'h00, 8'h00};
          3: {r, g, b} = {8'h00, 8'hff, 8'h00};
          4: {r, g, b} = {8'h00, 8'h00, 8'hff};
          default: ;
        endcase
      end
      PixExtreme: begin
        r = $urandom_range(0, 1) ? 8'hff : 8'h00;
        g = $urandom_range(0, 1) ? 8'hff : 8'h00;
        b = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      PixFlat: begin
        // Few gray levels, so the median often sees ties.
        case ($urandom_range(0, 3))
          0: level = 8'd0;
          1: level = 8'd127;
          2: level = 8'd128;
          default: level = 8'd255;
        endcase
        r = level;
        g = level;
        b = level;
      end
      default: ;
    endcase
    return {b, g, r};
  endfunction

  task automatic send_pixel(input logic [InDataW-1:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic run_pixels(input int n, input pix_mode_e mode);
    for (int i = 0; i < n; i++) send_pixel(make_pixel(mode, i));
  endtask

  // Waits until every queued result has come out, then lets the pipeline
  // drain pixels that produce no result.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic write_size(input logic [CfgDataW-1:0] wd, input logic [CfgDataW-1:0] hd,
                            input bit do_w, input bit do_h);
    bit width_first;
    width_first = 1'($urandom_range(0, 1));
    if (do_w && width_first) write_reg(CfgFrameWidth, wd, !do_h);
    if (do_h) write_reg(CfgFrameHeight, hd, !(do_w && !width_first));
    if (do_w && !width_first) write_reg(CfgFrameWidth, wd, 1'b1);
    if (do_w) cur_w = clamp_size(wd[WidthW-1:0], MaxWidth);
    if (do_h) cur_h = clamp_size(hd[HeightW-1:0], MaxHeight);
    settings_used++;
  endtask

  initial begin
    logic [CfgDataW-1:0] wd;
    logic [CfgDataW-1:0] hd;
    int                  n;
    int                  phase;
    int                  pick;
    int                  which;
    pix_mode_e           mode;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgFrameWidth;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    gap_max = 3;
    settle();

    // Reset size of 640 wide: the first line is all border, so nothing may come out.
    run_pixels(20, PixRandom);
    settle();

    // Sizes below the minimum saturate to 5x5; one frame mostly of primary and extreme colors.
    write_size(16'd3, 16'd2, 1'b1, 1'b1);
    run_pixels(25, PixCorner);
    settle();

    // A write to an unused index must not restart the frame, a size write must.
    write_size(16'd7, 16'd6, 1'b1, 1'b1);
    run_pixels(20, PixRandom);
    settle();
    write_reg(CfgSpare, CfgDataW'($urandom), 1'b1);
    run_pixels(30, PixRandom);
    settle();
    write_size(16'd7, 16'd6, 1'b0, 1'b1);
    run_pixels(84, PixRandom);
    settle();

    phase = 0;
    while (random_items < RandomTarget || phase < 2) begin
      wd = CfgDataW'($urandom);
      hd = CfgDataW'($urandom);
      pick = $urandom_range(0, 9);
      wd[WidthW-1:0] = (pick == 0) ? WidthW'($urandom_range(0, 4))
                                   : WidthW'($urandom_range(5, 12));
      hd[HeightW-1:0] = (pick == 1) ? HeightW'($urandom_range(0, 4))
                                    : HeightW'($urandom_range(5, 9));
      which = (phase == 0) ? 2 : $urandom_range(0, 3);
      write_size(wd, hd, which != 1, which != 0);
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 2;
        default: gap_max = 12;
      endcase
      case ($urandom_range(0, 4))
        0: mode = PixExtreme;
        1: mode = PixFlat;
        default: mode = PixRandom;
      endcase
      n = $urandom_range(1, 2) * cur_w * cur_h + $urandom_range(0, cur_w * cur_h - 1);
      if (phase == 1) begin
        // The output closes for a long stretch while pixels keep coming.
        hold_req <= hold_req + 1;
        gap_max = 0;
        if (n < PressureItems) n = PressureItems;
      end
      run_pixels(n, mode);
      random_items += n;
      phase++;
      settle();
    end

    // An oversized height saturates to 4096 on a narrow frame; the first lines
    // already hold interior centers.
    gap_max = 3;
    write_size(16'd6, 16'hffff, 1'b1, 1'b1);
    run_pixels(6 * 8, PixRandom);
    settle();

    // An oversized width saturates to 2048; the first line is border only.
    write_size(16'hffff, 16'd5, 1'b1, 1'b1);
    run_pixels(24, PixRandom);
    settle();

    // Tallest frame, one interior column, first lines only.
    gap_max = 0;
    write_size(16'd2, 16'd4096, 1'b1, 1'b1);
    run_pixels(5 * 12, PixRandom);
    settle();

    repeat (10) @(posedge clk_i);
    if (pending_count != 0) begin
      $display("tb: %0d expected results never arrived", pending_count);
    end
    $display("tb: %0d pixels over %0d size settings, from 5x5 up to 2048 wide and 4096 high",
             pixels_sent, settings_used);
    $display("tb: %0d filter results compared, %0d of them closing a frame",
             result_count, frame_end_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/g3m_pkg.sv
rtl/g3m_line_ram.sv
rtl/g3m_col_cell.sv
rtl/g3m_reduce.sv
rtl/gray_3x3_mean_median_gauss.sv
bench/g3m_filter_checker.sv
bench/tb.sv
